// ===== rtl/core/gbd_pkg.sv =====
// ----------------------------------------------------------------------------
// gbd_pkg
// Shared codes, widths and control structs of the grid distance map.
// ----------------------------------------------------------------------------
package gbd_pkg;

    localparam int DIST_W     = 13;
    localparam int CFG_W      = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int IN_COORD_W = 6;
    localparam int CNT_W      = 9;

    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_SEARCH = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;

    localparam logic KIND_SEARCH = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

    typedef struct packed {
        logic wall_we;
        logic dist_we;
        logic rd_en;
    } t_mem_ctl;

    typedef struct packed {
        logic              idle;
        logic              done;
        logic              blocked;
        logic [DIST_W-1:0] best;
    } t_flood_status;

endpackage

// ===== rtl/core/gbd_grid.sv =====
// ----------------------------------------------------------------------------
// gbd_grid
// Wall and distance memories of the grid, one write and one registered read
// port each, both read at the same cell address.
// ----------------------------------------------------------------------------
module gbd_grid
    import gbd_pkg::*;
#(
    parameter int ADDR_W = 12
) (
    input  logic              i_clk,
    input  t_mem_ctl          i_ctl,
    input  logic [ADDR_W-1:0] i_wall_wa,
    input  logic              i_wall_wd,
    input  logic [ADDR_W-1:0] i_dist_wa,
    input  logic [DIST_W-1:0] i_dist_wd,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic              o_wall_rd,
    output logic [DIST_W-1:0] o_dist_rd
);

    localparam int DEPTH = 1 << ADDR_W;

    logic              r_wall_mem [DEPTH];
    logic [DIST_W-1:0] r_dist_mem [DEPTH];
    logic              r_wall_rd;
    logic [DIST_W-1:0] r_dist_rd;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wall_we) begin
            r_wall_mem[i_wall_wa] <= i_wall_wd;
        end
        if (i_ctl.dist_we) begin
            r_dist_mem[i_dist_wa] <= i_dist_wd;
        end
        if (i_ctl.rd_en) begin
            r_wall_rd <= r_wall_mem[i_rd_addr];
            r_dist_rd <= r_dist_mem[i_rd_addr];
        end
    end

    assign o_wall_rd = r_wall_rd;
    assign o_dist_rd = r_dist_rd;

endmodule

// ===== rtl/core/gbd_flood.sv =====
// ----------------------------------------------------------------------------
// gbd_flood
// Search sequencer: after reset sweeps the distance memory to zero; per search
// clears the distances of the previous search, then walks the grid
// breadth-first over a coordinate queue, one neighbor at a time.
module gbd_flood
    import gbd_pkg::*;
#(
    parameter int ROW_W = 6,
    parameter int COL_W = 6,
    parameter int CELLS = 4096
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic                    i_start_ok,
    input  logic [ROW_W+COL_W-1:0]  i_start_addr,
    input  logic [CNT_W-1:0]        i_rows_used,
    input  logic [CNT_W-1:0]        i_cols_used,
    input  logic                    i_done_ack,
    input  logic                    i_wall_rd,
    input  logic [DIST_W-1:0]       i_dist_rd,
    output t_mem_ctl                o_mem_ctl,
    output logic [ROW_W+COL_W-1:0]  o_rd_addr,
    output logic [ROW_W+COL_W-1:0]  o_dist_wa,
    output logic [DIST_W-1:0]       o_dist_wd,
    output t_flood_status           o_status
);

    localparam int ADDR_W = ROW_W + COL_W;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int PTR_W  = ADDR_W + 1;
    localparam logic [PTR_W-1:0] CELLS_P = PTR_W'(CELLS);

    localparam logic [1:0] NB_UP    = 2'd0;
    localparam logic [1:0] NB_DOWN  = 2'd1;
    localparam logic [1:0] NB_LEFT  = 2'd2;
    localparam logic [1:0] NB_RIGHT = 2'd3;

    typedef enum logic [10:0] {
        S_INIT = 11'b000_0000_0001,
        S_IDLE = 11'b000_0000_0010,
        S_CLR  = 11'b000_0000_0100,
        S_SRD  = 11'b000_0000_1000,
        S_SCHK = 11'b000_0001_0000,
        S_POP  = 11'b000_0010_0000,
        S_CUR  = 11'b000_0100_0000,
        S_DIST = 11'b000_1000_0000,
        S_NB   = 11'b001_0000_0000,
        S_NCHK = 11'b010_0000_0000,
        S_DONE = 11'b100_0000_0000
    } t_state;

    t_state             r_state, n_state;
    logic [PTR_W-1:0]   r_idx, n_idx;
    logic [PTR_W-1:0]   r_head, n_head;
    logic [PTR_W-1:0]   r_tail, n_tail;
    logic               r_clr_pend, n_clr_pend;
    logic [1:0]         r_nb, n_nb;
    logic [DIST_W-1:0]  r_nd, n_nd;
    logic [DIST_W-1:0]  r_best, n_best;
    logic               r_blocked, n_blocked;
    logic [ADDR_W-1:0]  r_nb_addr, n_nb_addr;
    logic [ADDR_W-1:0]  r_start_addr, n_start_addr;
    logic               r_start_ok, n_start_ok;

    logic [ADDR_W-1:0]  r_queue [DEPTH];
    logic [ADDR_W-1:0]  r_q_rd;
    logic               q_re;
    logic [ADDR_W-1:0]  q_ra;
    logic               q_we;
    logic [ADDR_W-1:0]  q_wa;
    logic [ADDR_W-1:0]  q_wd;

    logic [ROW_W-1:0]   cur_row, nb_row;
    logic [COL_W-1:0]   cur_col, nb_col;
    logic               nb_ok;

    assign cur_row = r_q_rd[ADDR_W-1:COL_W];
    assign cur_col = r_q_rd[COL_W-1:0];

    always_comb begin
        nb_row = cur_row;
        nb_col = cur_col;
        nb_ok  = 1'b0;
        unique case (r_nb)
            NB_UP: begin
                nb_row = cur_row - ROW_W'(1);
                nb_ok  = (cur_row != '0);
            end
            NB_DOWN: begin
                nb_row = cur_row + ROW_W'(1);
                nb_ok  = ((CNT_W'(cur_row) + CNT_W'(1)) < i_rows_used);
            end
            NB_LEFT: begin
                nb_col = cur_col - COL_W'(1);
                nb_ok  = (cur_col != '0);
            end
            NB_RIGHT: begin
                nb_col = cur_col + COL_W'(1);
                nb_ok  = ((CNT_W'(cur_col) + CNT_W'(1)) < i_cols_used);
            end
            default: begin
                nb_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_head       = r_head;
        n_tail       = r_tail;
        n_clr_pend   = 1'b0;
        n_nb         = r_nb;
        n_nd         = r_nd;
        n_best       = r_best;
        n_blocked    = r_blocked;
        n_nb_addr    = r_nb_addr;
        n_start_addr = r_start_addr;
        n_start_ok   = r_start_ok;
        o_mem_ctl    = '0;
        o_rd_addr    = r_start_addr;
        o_dist_wa    = r_start_addr;
        o_dist_wd    = '0;
        q_re         = 1'b0;
        q_ra         = r_head[ADDR_W-1:0];
        q_we         = 1'b0;
        q_wa         = r_tail[ADDR_W-1:0];
        q_wd         = r_start_addr;

        unique case (r_state)
            S_INIT: begin
                o_mem_ctl.dist_we = 1'b1;
                o_dist_wa         = r_idx[ADDR_W-1:0];
                if (r_idx[ADDR_W-1:0] == '1) begin
                    n_idx   = '0;
                    n_tail  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + PTR_W'(1);
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_idx        = '0;
                    n_start_addr = i_start_addr;
                    n_start_ok   = i_start_ok;
                    n_state      = S_CLR;
                end
            end
            S_CLR: begin
                if (r_clr_pend) begin
                    o_mem_ctl.dist_we = 1'b1;
                    o_dist_wa         = r_q_rd;
                end
                if (r_idx < r_tail) begin
                    q_re       = 1'b1;
                    q_ra       = r_idx[ADDR_W-1:0];
                    n_idx      = r_idx + PTR_W'(1);
                    n_clr_pend = 1'b1;
                end else if (!r_clr_pend) begin
                    n_state = S_SRD;
                end
            end
            S_SRD: begin
                o_mem_ctl.rd_en = 1'b1;
                n_state         = S_SCHK;
            end
            S_SCHK: begin
                if (r_start_ok && !i_wall_rd) begin
                    o_mem_ctl.dist_we = 1'b1;
                    o_dist_wd         = DIST_W'(1);
                    q_we              = 1'b1;
                    q_wa              = '0;
                    n_head            = '0;
                    n_tail            = PTR_W'(1);
                    n_best            = DIST_W'(1);
                    n_blocked         = 1'b0;
                    n_state           = S_POP;
                end else begin
                    n_tail    = '0;
                    n_best    = '0;
                    n_blocked = 1'b1;
                    n_state   = S_DONE;
                end
            end
            S_POP: begin
                if (r_head < r_tail) begin
                    q_re    = 1'b1;
                    n_head  = r_head + PTR_W'(1);
                    n_state = S_CUR;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_CUR: begin
                o_mem_ctl.rd_en = 1'b1;
                o_rd_addr       = r_q_rd;
                n_state         = S_DIST;
            end
            S_DIST: begin
                if (i_dist_rd > r_best) begin
                    n_best = i_dist_rd;
                end
                n_nd    = i_dist_rd + DIST_W'(1);
                n_nb    = NB_UP;
                n_state = S_NB;
            end
            S_NB: begin
                if (nb_ok) begin
                    o_mem_ctl.rd_en = 1'b1;
                    o_rd_addr       = {nb_row, nb_col};
                    n_nb_addr       = {nb_row, nb_col};
                    n_state         = S_NCHK;
                end else if (r_nb == NB_RIGHT) begin
                    n_state = S_POP;
                end else begin
                    n_nb = r_nb + 2'd1;
                end
            end
            S_NCHK: begin
                if (!i_wall_rd && (i_dist_rd == '0) && (r_tail < CELLS_P)) begin
                    o_mem_ctl.dist_we = 1'b1;
                    o_dist_wa         = r_nb_addr;
                    o_dist_wd         = r_nd;
                    q_we              = 1'b1;
                    q_wd              = r_nb_addr;
                    n_tail            = r_tail + PTR_W'(1);
                end
                if (r_nb == NB_RIGHT) begin
                    n_state = S_POP;
                end else begin
                    n_nb    = r_nb + 2'd1;
                    n_state = S_NB;
                end
            end
            S_DONE: begin
                if (i_done_ack) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_idx      <= '0;
            r_head     <= '0;
            r_tail     <= '0;
            r_clr_pend <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_clr_pend <= n_clr_pend;
        end
        r_nb         <= n_nb;
        r_nd         <= n_nd;
        r_best       <= n_best;
        r_blocked    <= n_blocked;
        r_nb_addr    <= n_nb_addr;
        r_start_addr <= n_start_addr;
        r_start_ok   <= n_start_ok;
    end

    always_ff @(posedge i_clk) begin
        if (q_we) begin
            r_queue[q_wa] <= q_wd;
        end
        if (q_re) begin
            r_q_rd <= r_queue[q_ra];
        end
    end

    assign o_status.idle    = (r_state == S_IDLE);
    assign o_status.done    = (r_state == S_DONE);
    assign o_status.blocked = r_blocked;
    assign o_status.best    = r_best;

`ifndef SYNTH
    a_tail_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail <= CELLS_P)
        else $error("queue tail passed the cell count");

    a_head_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NB) |-> (r_head != '0 && r_head <= r_tail))
        else $error("queue head out of order during neighbor scan");

    a_blocked_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_blocked) |-> (r_best == '0))
        else $error("blocked search reports a distance");

    a_open_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_blocked) |-> (r_best != '0 && r_tail != '0))
        else $error("open search reports no reached cell");
`endif

endmodule

// ===== rtl/core/grid_bfs_distance_map.sv =====
// ----------------------------------------------------------------------------
// grid_bfs_distance_map
// Four-neighbor breadth-first distance map over a loadable occupancy grid.
//
//  Channel   Direction  Payload
//  s_axis    in         tuser: action; tdata: row, col, wall
//  m_axis    out        tuser: kind;   tdata: distance, blocked
//  cfg       in         write enable, register index, 7-bit data
//
// Load and read items are taken one per cycle while no search is running and no
// read answer waits behind a stalled result; a read answer passes the registered
// grid read and then the output register. A search item clears the distances
// of the cells that the previous search reached, checks the start cell and, if
// it is open, visits each reached cell and its neighbors in turn, all paced by
// the single read port of the grid memories.
// After reset the distance memory is swept to zero, one entry per cycle over its
// MAX_ROWS rounded up to a power of two times the same for MAX_COLS entries
// (4096 by default), while no item is accepted.
// A stalled result holds in the output register without blocking the input;
// a read accepted behind it holds the input until that result leaves.
// ----------------------------------------------------------------------------
module grid_bfs_distance_map
    import gbd_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [15:0]          i_s_axis_tdata,   // row[5:0], col[11:6], wall[12]
    input  logic [1:0]           i_s_axis_tuser,   // action[1:0]
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [15:0]          o_m_axis_tdata,   // distance[12:0], blocked[13]
    output logic [0:0]           o_m_axis_tuser,   // kind[0]
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]     i_cfg_wdata
);

    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int CELLS  = MAX_ROWS * MAX_COLS;
    localparam logic [CNT_W-1:0] MAX_ROWS_C = CNT_W'(MAX_ROWS);
    localparam logic [CNT_W-1:0] MAX_COLS_C = CNT_W'(MAX_COLS);

    logic [CFG_W-1:0]      r_rows;
    logic [CFG_W-1:0]      r_cols;
    logic [CNT_W-1:0]      rows_used;
    logic [CNT_W-1:0]      cols_used;

    logic [1:0]            in_action;
    logic [IN_COORD_W-1:0] in_row;
    logic [IN_COORD_W-1:0] in_col;
    logic                  in_wall;
    logic                  in_store;
    logic                  start_ok;
    logic [ADDR_W-1:0]     in_addr;
    logic                  in_acc;
    logic                  out_free;

    t_mem_ctl              host_ctl;
    t_mem_ctl              flood_ctl;
    t_mem_ctl              mem_ctl;
    t_flood_status         fl_status;
    logic                  flood_start;
    logic                  done_ack;
    logic [ADDR_W-1:0]     flood_rd_addr;
    logic [ADDR_W-1:0]     mem_rd_addr;
    logic [ADDR_W-1:0]     dist_wa;
    logic [DIST_W-1:0]     dist_wd;
    logic                  wall_rd;
    logic [DIST_W-1:0]     dist_rd;

    logic                  r_rd_pend, n_rd_pend;
    logic                  r_rd_inside;
    logic                  r_out_valid;
    logic                  r_out_kind;
    logic [DIST_W-1:0]     r_out_dist;
    logic                  r_out_blocked;

    assign in_action = i_s_axis_tuser;
    assign in_row    = i_s_axis_tdata[5:0];
    assign in_col    = i_s_axis_tdata[11:6];
    assign in_wall   = i_s_axis_tdata[12];

    assign rows_used = (CNT_W'(r_rows) < MAX_ROWS_C) ? CNT_W'(r_rows) : MAX_ROWS_C;
    assign cols_used = (CNT_W'(r_cols) < MAX_COLS_C) ? CNT_W'(r_cols) : MAX_COLS_C;

    assign in_store = (CNT_W'(in_row) < MAX_ROWS_C) && (CNT_W'(in_col) < MAX_COLS_C);
    assign start_ok = (CNT_W'(in_row) < rows_used) && (CNT_W'(in_col) < cols_used);
    assign in_addr  = {ROW_W'(in_row), COL_W'(in_col)};

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = fl_status.idle && (!r_rd_pend || out_free);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        host_ctl    = '0;
        flood_start = 1'b0;
        if (in_acc) begin
            unique case (in_action)
                ACT_LOAD:   host_ctl.wall_we = in_store;
                ACT_SEARCH: flood_start      = 1'b1;
                ACT_READ:   host_ctl.rd_en   = 1'b1;
                default:    host_ctl         = '0;
            endcase
        end
    end

    assign mem_ctl     = host_ctl | flood_ctl;
    assign mem_rd_addr = fl_status.idle ? in_addr : flood_rd_addr;
    assign n_rd_pend   = host_ctl.rd_en || (r_rd_pend && !out_free);
    assign done_ack    = fl_status.done && out_free && !r_rd_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= CFG_W'(64);
            r_cols <= CFG_W'(64);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_ROWS: r_rows <= i_cfg_wdata;
                CFG_COLS: r_cols <= i_cfg_wdata;
                default:  r_rows <= r_rows;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_pend <= n_rd_pend;
            if (out_free) begin
                r_out_valid <= r_rd_pend || fl_status.done;
            end
        end
        if (host_ctl.rd_en) begin
            r_rd_inside <= in_store;
        end
        if (out_free) begin
            if (r_rd_pend) begin
                r_out_kind    <= KIND_READ;
                r_out_dist    <= r_rd_inside ? dist_rd : '0;
                r_out_blocked <= r_rd_inside ? wall_rd : 1'b0;
            end else begin
                r_out_kind    <= KIND_SEARCH;
                r_out_dist    <= fl_status.best;
                r_out_blocked <= fl_status.blocked;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out_blocked, r_out_dist};
    assign o_m_axis_tuser  = r_out_kind;

    gbd_grid #(
        .ADDR_W (ADDR_W)
    ) u_grid (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_wall_wa (in_addr),
        .i_wall_wd (in_wall),
        .i_dist_wa (dist_wa),
        .i_dist_wd (dist_wd),
        .i_rd_addr (mem_rd_addr),
        .o_wall_rd (wall_rd),
        .o_dist_rd (dist_rd)
    );

    gbd_flood #(
        .ROW_W (ROW_W),
        .COL_W (COL_W),
        .CELLS (CELLS)
    ) u_flood (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (flood_start),
        .i_start_ok   (start_ok),
        .i_start_addr (in_addr),
        .i_rows_used  (rows_used),
        .i_cols_used  (cols_used),
        .i_done_ack   (done_ack),
        .i_wall_rd    (wall_rd),
        .i_dist_rd    (dist_rd),
        .o_mem_ctl    (flood_ctl),
        .o_rd_addr    (flood_rd_addr),
        .o_dist_wa    (dist_wa),
        .o_dist_wd    (dist_wd),
        .o_status     (fl_status)
    );

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for grid_bfs_distance_map. A directed table covers
// reset state, corner cells, blocked and out-of-grid starts and an ignored
// action code. Random phases then reprogram the grid size, load every cell
// in use and mix searches, reads, reloads and noise under random stalls.
// Every result is checked field by field against an in-bench flood
// predictor or, for some directed steps, a fixed expected answer.
// ----------------------------------------------------------------------------
module testbench
    import gbd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID_ROWS = 64;
    localparam int GRID_COLS = 64;
    localparam int GRID_CELLS = GRID_ROWS * GRID_COLS;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int ITEM_TARGET = 950;
    localparam int PLAN_LEN = 24;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic              kind;
        logic [DIST_W-1:0] dist_val;
        logic              blocked;
    } t_answer;

    typedef struct {
        bit         regrid;
        logic [1:0] act;
        logic [6:0] a;
        logic [6:0] b;
        logic       wall;
        bit         typed;
        t_answer    ans;
    } t_step;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [15:0]          s_tdata = '0;
    logic [1:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [15:0]          m_tdata;
    logic [0:0]           m_tuser;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    // Predictor state.
    bit              grid_wall [GRID_CELLS];
    bit [DIST_W-1:0] grid_dist [GRID_CELLS];
    int unsigned     flood_fifo [GRID_CELLS];
    int unsigned     fifo_tail;
    int unsigned     rows_used = GRID_ROWS;
    int unsigned     cols_used = GRID_COLS;

    // Cells whose wall bit has been loaded at least once.
    bit          wall_loaded [GRID_CELLS];
    int unsigned loaded_cells [$];

    t_answer pending_answers [$];
    t_step   plan [PLAN_LEN];
    bit      idle_on = 1'b1;
    int      ready_hold = 0;
    int      cycle_cnt = 0;
    int      fail_cnt = 0;
    int      checked_cnt = 0;
    int      items_sent = 0;
    int      load_cnt = 0;
    int      search_cnt = 0;
    int      read_cnt = 0;
    int      noise_cnt = 0;
    int      grid_settings = 0;
    int      longest_flood = 0;
    t_answer got;
    t_answer want;

    grid_bfs_distance_map #(
        .MAX_ROWS(GRID_ROWS),
        .MAX_COLS(GRID_COLS)
    ) u_dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata),     // row[5:0], col[11:6], wall[12]
        .i_s_axis_tuser(s_tuser),     // action[1:0]
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata),     // distance[12:0], blocked[13]
        .o_m_axis_tuser(m_tuser),     // kind[0]
        .i_cfg_we(cfg_we),
        .i_cfg_addr(cfg_addr),
        .i_cfg_wdata(cfg_wdata)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 9) < 8) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic void enqueue_cell(int unsigned r, int unsigned c, logic [DIST_W-1:0] d);
        int unsigned a;
        if (r >= rows_used || c >= cols_used) begin
            return;
        end
        a = r * GRID_COLS + c;
        if (grid_wall[a] || grid_dist[a] != 0 || fifo_tail >= GRID_CELLS) begin
            return;
        end
        grid_dist[a] = d;
        flood_fifo[fifo_tail] = a;
        fifo_tail++;
    endfunction

    function automatic logic [DIST_W-1:0] flood_from(int unsigned r0, int unsigned c0);
        int unsigned head;
        int unsigned cur;
        int unsigned r;
        int unsigned c;
        logic [DIST_W-1:0] d;
        logic [DIST_W-1:0] best;
        best = 1;
        grid_dist[r0 * GRID_COLS + c0] = 1;
        flood_fifo[0] = r0 * GRID_COLS + c0;
        head = 0;
        fifo_tail = 1;
        while (head < fifo_tail) begin
            cur = flood_fifo[head];
            head++;
            r = cur / GRID_COLS;
            c = cur % GRID_COLS;
            d = grid_dist[cur];
            if (d > best) begin
                best = d;
            end
            if (r > 0) begin
                enqueue_cell(r - 1, c, d + 1'b1);
            end
            enqueue_cell(r + 1, c, d + 1'b1);
            if (c > 0) begin
                enqueue_cell(r, c - 1, d + 1'b1);
            end
            enqueue_cell(r, c + 1, d + 1'b1);
        end
        return best;
    endfunction

    function automatic bit grid_predict(logic [1:0] act, logic [5:0] r, logic [5:0] c,
                                        logic w, output t_answer ans);
        int unsigned a;
        a = r * GRID_COLS + c;
        ans = '0;
        case (act)
            ACT_LOAD: begin
                grid_wall[a] = w;
                return 1'b0;
            end
            ACT_SEARCH: begin
                foreach (grid_dist[i]) begin
                    grid_dist[i] = '0;
                end
                fifo_tail = 0;
                ans.kind = KIND_SEARCH;
                if (r < rows_used && c < cols_used && !grid_wall[a]) begin
                    ans.dist_val = flood_from(r, c);
                    ans.blocked = 1'b0;
                end else begin
                    ans.blocked = 1'b1;
                end
                return 1'b1;
            end
            ACT_READ: begin
                ans.kind = KIND_READ;
                ans.dist_val = grid_dist[a];
                ans.blocked = grid_wall[a];
                return 1'b1;
            end
            default: begin
                return 1'b0;
            end
        endcase
    endfunction

    task automatic send_item(input logic [1:0] act, input logic [5:0] r, input logic [5:0] c,
                             input logic w, input bit typed, input t_answer typed_ans);
        int gap;
        bit has_ans;
        t_answer ans;
        int unsigned a;
        gap = (idle_on && $urandom_range(0, 1) == 1) ? gap_len() : 0;
        a = r * GRID_COLS + c;
        @(negedge clk);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {3'b000, w, c, r};
        s_tuser <= act;
        do @(posedge clk); while (!s_tready);
        has_ans = grid_predict(act, r, c, w, ans);
        if (has_ans) begin
            pending_answers.push_back(typed ? typed_ans : ans);
        end
        items_sent++;
        case (act)
            ACT_LOAD: begin
                load_cnt++;
                if (!wall_loaded[a]) begin
                    wall_loaded[a] = 1'b1;
                    loaded_cells.push_back(a);
                end
            end
            ACT_SEARCH: begin
                search_cnt++;
                if (int'(ans.dist_val) > longest_flood) begin
                    longest_flood = int'(ans.dist_val);
                end
            end
            ACT_READ: read_cnt++;
            default: noise_cnt++;
        endcase
    endtask

    task automatic settle_block();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic set_grid(input logic [6:0] n_rows, input logic [6:0] n_cols);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= CFG_ROWS;
        cfg_wdata <= n_rows;
        @(negedge clk);
        cfg_addr <= CFG_COLS;
        cfg_wdata <= n_cols;
        @(negedge clk);
        cfg_we <= 1'b0;
        rows_used = (n_rows < GRID_ROWS) ? n_rows : GRID_ROWS;
        cols_used = (n_cols < GRID_COLS) ? n_cols : GRID_COLS;
        grid_settings++;
    endtask

    task automatic log_error(input string msg);
        fail_cnt++;
        if (fail_cnt <= 10) begin
            $display("ERROR at cycle %0d: %s", cycle_cnt, msg);
        end
    endtask

    always @(negedge clk) begin
        if (!idle_on) begin
            m_tready <= 1'b1;
            ready_hold = 0;
        end else if (ready_hold > 0) begin
            ready_hold--;
        end else if ($urandom_range(0, 2) != 0) begin
            m_tready <= 1'b1;
            ready_hold = $urandom_range(0, 6);
        end else begin
            m_tready <= 1'b0;
            ready_hold = gap_len() - 1;
        end
    end

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            got = '{m_tuser[0], m_tdata[DIST_W-1:0], m_tdata[DIST_W]};
            if (pending_answers.size() == 0) begin
                log_error($sformatf("unexpected result kind %0d distance %0d blocked %0d",
                                    got.kind, got.dist_val, got.blocked));
            end else begin
                want = pending_answers.pop_front();
                checked_cnt++;
                if (got.kind !== want.kind) begin
                    log_error($sformatf("kind expected %0d, got %0d", want.kind, got.kind));
                end
                if (got.dist_val !== want.dist_val) begin
                    log_error($sformatf("distance expected %0d, got %0d (kind %0d)",
                                        want.dist_val, got.dist_val, want.kind));
                end
                if (got.blocked !== want.blocked) begin
                    log_error($sformatf("blocked expected %0d, got %0d (kind %0d)",
                                        want.blocked, got.blocked, want.kind));
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding.",
                     cycle_cnt, pending_answers.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int          rr;
        int          cc;
        int          pick;
        int          density;
        int          n_ops;
        bit          serpentine;
        logic [6:0]  n_rows;
        logic [6:0]  n_cols;
        logic [5:0]  r;
        logic [5:0]  c;
        logic        w;
        int unsigned a;

        // The reset grid size is used first, so only corner cells are touched.
        plan = '{
            '{1'b0, ACT_LOAD,   7'd0,  7'd0,  1'b0, 1'b0, '0},
            '{1'b0, ACT_LOAD,   7'd63, 7'd63, 1'b1, 1'b0, '0},
            '{1'b0, ACT_LOAD,   7'd0,  7'd63, 1'b1, 1'b0, '0},
            '{1'b0, ACT_LOAD,   7'd63, 7'd0,  1'b0, 1'b0, '0},
            '{1'b0, ACT_READ,   7'd0,  7'd0,  1'b0, 1'b1, '{KIND_READ, 13'd0, 1'b0}},
            '{1'b0, ACT_READ,   7'd63, 7'd63, 1'b1, 1'b1, '{KIND_READ, 13'd0, 1'b1}},
            '{1'b0, ACT_SEARCH, 7'd63, 7'd63, 1'b0, 1'b1, '{KIND_SEARCH, 13'd0, 1'b1}},
            '{1'b0, ACT_UNUSED, 7'd63, 7'd63, 1'b1, 1'b0, '0},
            '{1'b0, ACT_READ,   7'd0,  7'd63, 1'b0, 1'b1, '{KIND_READ, 13'd0, 1'b1}},
            '{1'b1, ACT_LOAD,   7'd2,  7'd2,  1'b0, 1'b0, '0},
            '{1'b0, ACT_LOAD,   7'd0,  7'd0,  1'b0, 1'b0, '0},
            '{1'b0, ACT_LOAD,   7'd0,  7'd1,  1'b0, 1'b0, '0},
            '{1'b0, ACT_LOAD,   7'd1,  7'd0,  1'b0, 1'b0, '0},
            '{1'b0, ACT_LOAD,   7'd1,  7'd1,  1'b1, 1'b0, '0},
            '{1'b0, ACT_SEARCH, 7'd0,  7'd0,  1'b0, 1'b0, '0},
            '{1'b0, ACT_READ,   7'd0,  7'd1,  1'b0, 1'b0, '0},
            '{1'b0, ACT_READ,   7'd1,  7'd1,  1'b0, 1'b1, '{KIND_READ, 13'd0, 1'b1}},
            '{1'b0, ACT_SEARCH, 7'd1,  7'd1,  1'b0, 1'b1, '{KIND_SEARCH, 13'd0, 1'b1}},
            '{1'b0, ACT_READ,   7'd0,  7'd0,  1'b0, 1'b1, '{KIND_READ, 13'd0, 1'b0}},
            '{1'b0, ACT_SEARCH, 7'd1,  7'd0,  1'b0, 1'b0, '0},
            '{1'b0, ACT_SEARCH, 7'd5,  7'd0,  1'b0, 1'b1, '{KIND_SEARCH, 13'd0, 1'b1}},
            '{1'b1, ACT_LOAD,   7'd0,  7'd2,  1'b0, 1'b0, '0},
            '{1'b0, ACT_SEARCH, 7'd0,  7'd0,  1'b0, 1'b1, '{KIND_SEARCH, 13'd0, 1'b1}},
            '{1'b0, ACT_READ,   7'd0,  7'd0,  1'b0, 1'b1, '{KIND_READ, 13'd0, 1'b0}}
        };

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].regrid) begin
                settle_block();
                set_grid(plan[i].a, plan[i].b);
            end else begin
                send_item(plan[i].act, plan[i].a[5:0], plan[i].b[5:0], plan[i].wall,
                          plan[i].typed, plan[i].ans);
            end
        end

        while (items_sent < ITEM_TARGET) begin
            settle_block();
            idle_on = ($urandom_range(0, 3) != 0);
            n_rows = 7'($urandom_range(1, 10));
            n_cols = 7'($urandom_range(1, 10));
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                n_rows = ($urandom_range(0, 1) == 1) ? 7'd64 : 7'd127;
                n_cols = 7'($urandom_range(1, 6));
            end else if (pick == 1) begin
                n_rows = 7'($urandom_range(1, 6));
                n_cols = ($urandom_range(0, 1) == 1) ? 7'd64 : 7'd127;
            end else if (pick == 2) begin
                if ($urandom_range(0, 1) == 1) begin
                    n_rows = 7'd0;
                end else begin
                    n_cols = 7'd0;
                end
            end
            set_grid(n_rows, n_cols);

            // Fill every cell in use, either as a winding corridor or at random.
            serpentine = ($urandom_range(0, 3) == 0) && rows_used >= 3 && cols_used >= 2;
            density = $urandom_range(0, 45);
            for (rr = 0; rr < int'(rows_used); rr++) begin
                for (cc = 0; cc < int'(cols_used); cc++) begin
                    if (serpentine) begin
                        w = (rr % 2 == 1) &&
                            (cc != ((rr % 4 == 1) ? int'(cols_used) - 1 : 0));
                    end else begin
                        w = ($urandom_range(0, 99) < density);
                    end
                    send_item(ACT_LOAD, 6'(rr), 6'(cc), w, 1'b0, '0);
                end
            end

            n_ops = $urandom_range(20, 50);
            repeat (n_ops) begin
                pick = $urandom_range(0, 99);
                r = 6'($urandom_range(0, GRID_ROWS - 1));
                c = 6'($urandom_range(0, GRID_COLS - 1));
                w = 1'($urandom_range(0, 1));
                if (rows_used != 0 && cols_used != 0 &&
                    (pick < 72 || (pick >= 72 && pick < 84))) begin
                    if (pick >= 60 && pick < 72) begin
                        a = loaded_cells[$urandom_range(0, loaded_cells.size() - 1)];
                        r = 6'(a / GRID_COLS);
                        c = 6'(a % GRID_COLS);
                    end else if (!(pick < 18 && $urandom_range(0, 9) >= 8)) begin
                        r = 6'($urandom_range(0, rows_used - 1));
                        c = 6'($urandom_range(0, cols_used - 1));
                        if (pick < 18 && $urandom_range(0, 1) == 1) begin
                            r = 6'd0;
                            c = 6'd0;
                        end
                    end
                end else if (pick >= 18 && pick < 72) begin
                    a = loaded_cells[$urandom_range(0, loaded_cells.size() - 1)];
                    r = 6'(a / GRID_COLS);
                    c = 6'(a % GRID_COLS);
                end
                if (pick < 18) begin
                    send_item(ACT_SEARCH, r, c, w, 1'b0, '0);
                end else if (pick < 72) begin
                    send_item(ACT_READ, r, c, w, 1'b0, '0);
                end else if (pick < 92) begin
                    send_item(ACT_LOAD, r, c, w, 1'b0, '0);
                end else begin
                    send_item(ACT_UNUSED, r, c, w, 1'b0, '0);
                end
            end
        end

        settle_block();
        repeat (40) @(posedge clk);
        $display("Sent %0d loads, %0d searches, %0d reads and %0d ignored items",
                 load_cnt, search_cnt, read_cnt, noise_cnt);
        $display("over %0d grid sizes.", grid_settings);
        $display("Checked %0d results; longest flood distance %0d; %0d errors.",
                 checked_cnt, longest_flood, fail_cnt);
        if (fail_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
